// ===== src/wat_pkg.sv =====
`default_nettype none

package wat_pkg;

    // Table geometry
    localparam int ENTRIES_DEF = 16;

    // Field widths
    localparam int SLOT_W = 4;
    localparam int DAYS_W = 7;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int DUR_W  = 16;
    localparam int DAY_W  = 5;
    localparam int WDAY_W = 3;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes
    localparam logic [0:0] REG_ENABLED = 1'b0;

    // Request kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // One stored alarm entry
    typedef struct packed {
        logic              en;
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [DUR_W-1:0]  dur;
    } t_entry;

    // Clock values broadcast to all cells on a check
    typedef struct packed {
        logic [DAYS_W-1:0] today;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } t_check;

    // Scan payload moved from cell to cell
    typedef struct packed {
        logic             hit;
        logic [DUR_W-1:0] dur;
    } t_scan;

    // Cell control group
    typedef struct packed {
        logic load;
        logic check;
        logic clear_day;
        logic shift;
    } t_cell_ctl;

    // Weekday (0 = Sunday) to mask bit (bit 0 = Monday, bit 6 = Sunday)
    function automatic logic [DAYS_W-1:0] today_mask(input logic [WDAY_W-1:0] wd);
        logic [DAYS_W-1:0] m;
        begin
            case (wd)
                3'd0:    m = 7'b1000000;
                3'd1:    m = 7'b0000001;
                3'd2:    m = 7'b0000010;
                3'd3:    m = 7'b0000100;
                3'd4:    m = 7'b0001000;
                3'd5:    m = 7'b0010000;
                3'd6:    m = 7'b0100000;
                default: m = 7'b1000000;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/wat_if.sv =====
`default_nettype none

// Request channel: table loads and clock checks
interface wat_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [wat_pkg::SLOT_W-1:0] slot;
    logic                       entry_enable;
    logic [wat_pkg::DAYS_W-1:0] entry_days;
    logic [wat_pkg::HOUR_W-1:0] entry_hour;
    logic [wat_pkg::MIN_W-1:0]  entry_minute;
    logic [wat_pkg::DUR_W-1:0]  entry_duration;
    logic [wat_pkg::DAY_W-1:0]  day_of_month;
    logic [wat_pkg::WDAY_W-1:0] weekday;
    logic [wat_pkg::HOUR_W-1:0] clock_hour;
    logic [wat_pkg::MIN_W-1:0]  clock_minute;

    modport source (
        output valid, action, slot, entry_enable, entry_days, entry_hour,
               entry_minute, entry_duration, day_of_month, weekday,
               clock_hour, clock_minute,
        input  ready
    );
    modport sink (
        input  valid, action, slot, entry_enable, entry_days, entry_hour,
               entry_minute, entry_duration, day_of_month, weekday,
               clock_hour, clock_minute,
        output ready
    );
endinterface

// Result channel: one request per fired entry
interface wat_out_if;
    logic                       valid;
    logic                       ready;
    logic [wat_pkg::SLOT_W-1:0] fired_slot;
    logic [wat_pkg::DUR_W-1:0]  fired_duration;
    logic                       last;

    modport source (
        output valid, fired_slot, fired_duration, last,
        input  ready
    );
    modport sink (
        input  valid, fired_slot, fired_duration, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/wat_cell.sv =====
`default_nettype none

module wat_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wat_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_sel,
    input  wire wat_pkg::t_entry    i_entry,
    input  wire wat_pkg::t_check    i_chk,
    input  wire wat_pkg::t_scan     i_next,
    output wat_pkg::t_scan          o_scan
);

    wat_pkg::t_entry r_entry;
    logic            r_fired;
    wat_pkg::t_scan  r_scan;

    logic w_fired_eff;
    logic w_match;

    // Drop the fired flag on a new calendar day, then match this entry
    assign w_fired_eff = r_fired && !i_ctl.clear_day;
    assign w_match     = r_entry.en && !w_fired_eff
                      && (|(r_entry.days & i_chk.today))
                      && (r_entry.hour == i_chk.hour)
                      && (r_entry.minute == i_chk.minute);

    // Hold the entry, latch the hit on a check, pass scan data down the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_fired <= 1'b0;
            r_scan  <= '0;
        end else begin
            if (i_ctl.load && i_sel) begin
                r_entry <= i_entry;
                r_fired <= 1'b0;
            end
            if (i_ctl.check) begin
                r_fired     <= w_fired_eff || w_match;
                r_scan.hit  <= w_match;
                r_scan.dur  <= r_entry.dur;
            end else if (i_ctl.shift) begin
                r_scan <= i_next;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

// ===== src/weekly_alarm_table_matcher.sv =====
`default_nettype none

// Weekly alarm table matcher.
// Request channel (i_req): action selects a table load or a clock check.
// A load writes one entry and clears its fired flag and gives no result. A
// check (while the enabled register is 1) compares all entries against the
// clock at once, then walks the row of cells, one entry per cycle while the
// output register can take a result, so ready stays low through the walk
// and the flush. A check while disabled is absorbed and gives no result.
// Result channel (o_res): one request per fired entry in ascending slot
// order; last marks the final one. A hit is held in a pending register until
// the next hit or the end of the walk decides its last bit. The output is
// registered; a stall on o_res.ready freezes the walk until the output drains.
// A new request is taken only after the walk and flush of a check are over.
// Reset: table, fired flags and previous day clear to zero, enabled to 1.
// APB register 0 (byte address 0): bit 0 enabled; pready is always high.

module weekly_alarm_table_matcher #(
    parameter int ENTRIES = wat_pkg::ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    wat_in_if.sink                          i_req,
    wat_out_if.source                       o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wat_pkg::ADDR_W-1:0] paddr,
    input  wire logic [wat_pkg::DATA_W-1:0] pwdata,
    output logic      [wat_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_enabled;
    logic [wat_pkg::DAY_W-1:0]  r_prev_day;
    logic                       r_pend_vld, n_pend_vld;
    logic [wat_pkg::SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic [wat_pkg::DUR_W-1:0]  r_pend_dur, n_pend_dur;
    logic                       r_out_vld, n_out_vld;
    logic [wat_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [wat_pkg::DUR_W-1:0]  r_out_dur, n_out_dur;
    logic                       r_out_last, n_out_last;

    logic                 w_accept;
    logic                 w_do_check;
    logic                 w_do_load;
    logic                 w_out_free;
    logic                 w_step;
    wat_pkg::t_cell_ctl   w_ctl;
    wat_pkg::t_entry      w_entry;
    wat_pkg::t_check      w_chk;
    logic [ENTRIES-1:0]   w_sel;
    wat_pkg::t_scan       w_scan [ENTRIES];
    wat_pkg::t_scan       w_head;
    logic                 w_cfg_wr;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == wat_pkg::REG_ENABLED);
    assign prdata   = (paddr[2] == wat_pkg::REG_ENABLED)
                    ? {{(wat_pkg::DATA_W-1){1'b0}}, r_enabled} : '0;

    // Request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_do_check  = w_accept && (i_req.action == wat_pkg::ACT_CHECK) && r_enabled;
    assign w_do_load   = w_accept && (i_req.action == wat_pkg::ACT_LOAD);
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_step      = (r_state == S_SCAN) && w_out_free;

    assign w_ctl.load      = w_do_load;
    assign w_ctl.check     = w_do_check;
    assign w_ctl.clear_day = (i_req.day_of_month != r_prev_day);
    assign w_ctl.shift     = w_step;

    assign w_entry.en     = i_req.entry_enable;
    assign w_entry.days   = i_req.entry_days;
    assign w_entry.hour   = i_req.entry_hour;
    assign w_entry.minute = i_req.entry_minute;
    assign w_entry.dur    = i_req.entry_duration;

    assign w_chk.today  = wat_pkg::today_mask(i_req.weekday);
    assign w_chk.hour   = i_req.clock_hour;
    assign w_chk.minute = i_req.clock_minute;

    // Row of entry cells; scan data moves toward cell 0
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        wat_pkg::t_scan w_next;

        assign w_sel[g] = (int'(i_req.slot) == g);
        if (g == ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_scan[g+1];
        end

        wat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_sel   (w_sel[g]),
            .i_entry (w_entry),
            .i_chk   (w_chk),
            .i_next  (w_next),
            .o_scan  (w_scan[g])
        );
    end

    assign w_head = w_scan[0];

    // Walk control, pending hit and output register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_pend_dur  = r_pend_dur;
        n_out_vld   = r_out_vld && !o_res.ready;
        n_out_slot  = r_out_slot;
        n_out_dur   = r_out_dur;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_do_check) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step) begin
                    if (w_head.hit) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_slot = r_pend_slot;
                            n_out_dur  = r_pend_dur;
                            n_out_last = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = wat_pkg::SLOT_W'(r_cnt);
                        n_pend_dur  = w_head.dur;
                    end
                    if (r_cnt == CW'(ENTRIES - 1)) begin
                        n_cnt   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_slot = r_pend_slot;
                    n_out_dur  = r_pend_dur;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_enabled  <= 1'b1;
            r_prev_day <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (w_cfg_wr) begin
                r_enabled <= pwdata[0];
            end
            if (w_do_check) begin
                r_prev_day <= i_req.day_of_month;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_pend_dur  <= n_pend_dur;
        r_out_slot  <= n_out_slot;
        r_out_dur   <= n_out_dur;
        r_out_last  <= n_out_last;
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.fired_slot     = r_out_slot;
    assign o_res.fired_duration = r_out_dur;
    assign o_res.last           = r_out_last;

    // No hit is left pending once the walk is over
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("pending hit left while idle");

    // Walk counter starts from entry 0
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("walk counter not cleared while idle");

    // An enabled check starts a walk
    a_check_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_check |=> (r_state == S_SCAN))
        else $error("check did not start a walk");

    // Flushing the pending hit produces a result marked last
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && r_pend_vld && w_out_free)
        |=> (o_res.valid && o_res.last))
        else $error("final result not marked last");

endmodule

`default_nettype wire
